// ----- rtl/core/ctbl_pkg.sv -----
// Shared definitions for the cursor text buffer.
// Opcode codes, the result word layout and the memory control word; no dependencies.
package ctbl_pkg;

    localparam logic [2:0] OP_LEFT      = 3'd0;
    localparam logic [2:0] OP_RIGHT     = 3'd1;
    localparam logic [2:0] OP_BACKSPACE = 3'd2;
    localparam logic [2:0] OP_INSERT    = 3'd3;
    localparam logic [2:0] OP_REWIND    = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    localparam int CHAR_W   = 8;
    localparam int LENGTH_W = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              read_valid;
        logic              read_done;
        logic              pool_full;
    } ctbl_res_t;

    typedef struct packed {
        logic en;
        logic we;
    } ctbl_mem_ctl_t;

endpackage

// ----- rtl/core/ctbl_spram.sv -----
// Single-port synchronous RAM with a registered read port, no reset.
// Depends on ctbl_pkg for the enable/write control word.
module ctbl_spram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  ctbl_pkg::ctbl_mem_ctl_t    ctl,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic [WIDTH-1:0]           wdata,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/cursor_text_buffer_linked.sv -----
// Cursor text buffer: doubly linked list of characters held in node memories.
// Depends on ctbl_pkg and ctbl_spram.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------------
//  in      | in_valid / in_ready    | opcode, char_in
//  out     | out_valid / out_ready  | read_char, read_valid, read_done, text_length,
//          |                        | pool_full
//
// Left, right, backspace, rewind and unused codes go from RD1 to RES, as do
// a dropped insert and a read next with nothing left; other inserts pass WR2 and
// reads RD2, a second pass over the single-port memories. in_ready is high in idle.
// A finished result sits in the output register while the next word is taken;
// the block holds only if that register is still full when the next result is due.
// Reset clears cursor, allocation, count, read pointer and the head link at once.
module cursor_text_buffer_linked #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_char,
    output logic        read_valid,
    output logic        read_done,
    output logic [9:0]  text_length,
    output logic        pool_full
);

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = (IW > ctbl_pkg::LENGTH_W) ? IW : ctbl_pkg::LENGTH_W;
    localparam logic [IW-1:0] LAST_NODE = IW'(POOL_DEPTH - 1);
    localparam logic [IW-1:0] NONE      = '0;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;
    localparam logic [2:0] S_RD2  = 3'd2;
    localparam logic [2:0] S_WR2  = 3'd3;
    localparam logic [2:0] S_RES  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    op_reg;
    logic [7:0]    ch_reg;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic [IW-1:0] alloc_reg, alloc_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] read_node_reg, read_node_next;
    logic [IW-1:0] head_next_reg, head_next_next;
    logic [IW-1:0] node_reg, node_next;
    ctbl_pkg::ctbl_res_t res_reg, res_next;
    ctbl_pkg::ctbl_res_t out_res_reg;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_count_reg;

    ctbl_pkg::ctbl_mem_ctl_t cs_ctl, pl_ctl, nl_ctl;
    logic [IW-1:0] cs_addr, pl_addr, nl_addr;
    logic [7:0]    cs_wdata, cs_rdata;
    logic [IW-1:0] pl_wdata, pl_rdata, nl_wdata, nl_rdata;

    logic          accept;
    logic          is_full;
    logic [IW-1:0] fresh;
    logic [IW-1:0] cur_succ;
    logic [IW-1:0] read_succ;

    ctbl_spram #(.WIDTH(8), .DEPTH(POOL_DEPTH)) u_char_store (
        .clk(clk), .ctl(cs_ctl), .addr(cs_addr), .wdata(cs_wdata), .rdata(cs_rdata)
    );
    ctbl_spram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_prev_link (
        .clk(clk), .ctl(pl_ctl), .addr(pl_addr), .wdata(pl_wdata), .rdata(pl_rdata)
    );
    ctbl_spram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_next_link (
        .clk(clk), .ctl(nl_ctl), .addr(nl_addr), .wdata(nl_wdata), .rdata(nl_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_full  = (alloc_reg >= LAST_NODE);
    assign fresh    = alloc_reg + IW'(1);
    // head link lives in a register; the memory entry for node 0 is never used
    assign cur_succ  = (cursor_reg == NONE) ? head_next_reg : nl_rdata;
    assign read_succ = (read_node_reg == NONE) ? head_next_reg : nl_rdata;

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        alloc_next     = alloc_reg;
        count_next     = count_reg;
        read_node_next = read_node_reg;
        head_next_next = head_next_reg;
        node_next      = node_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        cs_ctl = '0; cs_addr = NONE;  cs_wdata = '0;
        pl_ctl = '0; pl_addr = NONE;  pl_wdata = NONE;
        nl_ctl = '0; nl_addr = NONE;  nl_wdata = NONE;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    nl_ctl.en  = 1'b1;
                    nl_addr    = (opcode == ctbl_pkg::OP_READ) ? read_node_reg : cursor_reg;
                    pl_ctl.en  = 1'b1;
                    pl_addr    = cursor_reg;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                state_next = S_RES;
                unique case (op_reg)
                    ctbl_pkg::OP_LEFT:
                    begin
                        if (cursor_reg != NONE)
                            cursor_next = pl_rdata;
                    end
                    ctbl_pkg::OP_RIGHT:
                    begin
                        if (cur_succ != NONE)
                            cursor_next = cur_succ;
                    end
                    ctbl_pkg::OP_BACKSPACE:
                    begin
                        if (cursor_reg != NONE)
                        begin
                            // unlink: next of predecessor, prev of successor
                            if (pl_rdata == NONE)
                                head_next_next = nl_rdata;
                            else
                            begin
                                nl_ctl   = '{en: 1'b1, we: 1'b1};
                                nl_addr  = pl_rdata;
                                nl_wdata = nl_rdata;
                            end
                            if (nl_rdata != NONE)
                            begin
                                pl_ctl   = '{en: 1'b1, we: 1'b1};
                                pl_addr  = nl_rdata;
                                pl_wdata = pl_rdata;
                            end
                            if (count_reg != '0)
                                count_next = count_reg - CW'(1);
                            cursor_next = pl_rdata;
                        end
                    end
                    ctbl_pkg::OP_INSERT:
                    begin
                        if (is_full)
                            res_next.pool_full = 1'b1;
                        else
                        begin
                            cs_ctl   = '{en: 1'b1, we: 1'b1};
                            cs_addr  = fresh;
                            cs_wdata = ch_reg;
                            pl_ctl   = '{en: 1'b1, we: 1'b1};
                            pl_addr  = fresh;
                            pl_wdata = cursor_reg;
                            nl_ctl   = '{en: 1'b1, we: 1'b1};
                            nl_addr  = fresh;
                            nl_wdata = cur_succ;
                            node_next  = cur_succ;
                            state_next = S_WR2;
                        end
                    end
                    ctbl_pkg::OP_REWIND:
                    begin
                        read_node_next = NONE;
                    end
                    ctbl_pkg::OP_READ:
                    begin
                        if (read_succ == NONE)
                            res_next.read_done = 1'b1;
                        else
                        begin
                            cs_ctl.en  = 1'b1;
                            cs_addr    = read_succ;
                            nl_ctl.en  = 1'b1;
                            nl_addr    = read_succ;
                            node_next  = read_succ;
                            state_next = S_RD2;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WR2:
            begin
                // second half of insert: splice the fresh node into its neighbours
                if (node_reg != NONE)
                begin
                    pl_ctl   = '{en: 1'b1, we: 1'b1};
                    pl_addr  = node_reg;
                    pl_wdata = fresh;
                end
                if (cursor_reg == NONE)
                    head_next_next = fresh;
                else
                begin
                    nl_ctl   = '{en: 1'b1, we: 1'b1};
                    nl_addr  = cursor_reg;
                    nl_wdata = fresh;
                end
                count_next  = count_reg + CW'(1);
                alloc_next  = fresh;
                cursor_next = fresh;
                state_next  = S_RES;
            end
            S_RD2:
            begin
                res_next.read_char  = cs_rdata;
                res_next.read_valid = 1'b1;
                res_next.read_done  = (nl_rdata == NONE);
                read_node_next      = node_reg;
                state_next          = S_RES;
            end
            S_RES:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= NONE;
            alloc_reg     <= NONE;
            count_reg     <= '0;
            read_node_reg <= NONE;
            head_next_reg <= NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            alloc_reg     <= alloc_next;
            count_reg     <= count_next;
            read_node_reg <= read_node_next;
            head_next_reg <= head_next_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= opcode;
            ch_reg <= char_in;
        end
        node_reg <= node_next;
        res_reg  <= res_next;
        if (state_reg == S_RES && (!out_valid_reg || out_ready))
        begin
            out_res_reg   <= res_reg;
            out_count_reg <= count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_char   = out_res_reg.read_char;
    assign read_valid  = out_res_reg.read_valid;
    assign read_done   = out_res_reg.read_done;
    assign pool_full   = out_res_reg.pool_full;
    assign text_length = out_count_reg[ctbl_pkg::LENGTH_W-1:0];

endmodule
